@@ rtl/cct_pkg.sv @@
// shared types and character constants for the character class tokenizer
`timescale 1ns / 1ps

package cct_pkg;

  localparam int CHAR_W = 21;

  // single-character symbols, each a token of its own, except the quotes, which open a string token
  localparam int SYM_COUNT = 19;
  localparam logic [CHAR_W-1:0] SYM_CODES [SYM_COUNT] = '{
    21'h26, 21'h3F, 21'h3B, 21'h24, 21'h23, 21'h40, 21'h5E, 21'h3A, 21'h22,
    21'h27, 21'h7C, 21'h2E, 21'h2C, 21'h28, 21'h29, 21'h7B, 21'h7D, 21'h5B,
    21'h5D
  };

  // operator characters, runs of them join into one token
  localparam int OP_COUNT = 8;
  localparam logic [CHAR_W-1:0] OP_CODES [OP_COUNT] = '{
    21'h3C, 21'h3E, 21'h21, 21'h3D, 21'h2B, 21'h2D, 21'h2A, 21'h2F
  };

  localparam logic [CHAR_W-1:0] CH_SPACE     = 21'h20;
  localparam logic [CHAR_W-1:0] CH_TAB       = 21'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 21'h0A;
  localparam logic [CHAR_W-1:0] CH_DQUOTE    = 21'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE    = 21'h27;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 21'h5C;

  // class flags of one character
  typedef struct packed {
    logic is_sym;
    logic is_dquote;
    logic is_squote;
    logic is_op;
    logic is_blank;
    logic is_newline;
    logic is_backslash;
  } char_class_t;

  // one result beat
  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              part_of_token;
    logic              break_before;
    logic              break_after;
    logic              line_end;
    logic              string_mode;
    logic              stream_end;
  } result_t;

endpackage

@@ rtl/cct_class.sv @@
// character classifier: parallel compares against the fixed character sets
`timescale 1ns / 1ps

module cct_class (
  input  logic [cct_pkg::CHAR_W-1:0] char_code,
  output cct_pkg::char_class_t       cls
);

  logic sym_hit;
  logic op_hit;

  // set membership, one compare per entry
  always_comb begin
    sym_hit = 1'b0;
    op_hit  = 1'b0;
    for (int i = 0; i < cct_pkg::SYM_COUNT; i++) begin
      if (char_code == cct_pkg::SYM_CODES[i]) sym_hit = 1'b1;
    end
    for (int i = 0; i < cct_pkg::OP_COUNT; i++) begin
      if (char_code == cct_pkg::OP_CODES[i]) op_hit = 1'b1;
    end
  end

  // pack the class flags
  always_comb begin
    cls.is_sym       = sym_hit;
    cls.is_dquote    = (char_code == cct_pkg::CH_DQUOTE);
    cls.is_squote    = (char_code == cct_pkg::CH_SQUOTE);
    cls.is_op        = op_hit;
    cls.is_blank     = (char_code == cct_pkg::CH_SPACE) || (char_code == cct_pkg::CH_TAB);
    cls.is_newline   = (char_code == cct_pkg::CH_NEWLINE);
    cls.is_backslash = (char_code == cct_pkg::CH_BACKSLASH);
  end

endmodule

@@ rtl/cct_core.sv @@
// tokenizer state and per-character result logic
`timescale 1ns / 1ps

module cct_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       flush,
  input  logic [cct_pkg::CHAR_W-1:0] char_code,
  input  cct_pkg::char_class_t       cls,
  output cct_pkg::result_t           res
);

  logic token_open, token_open_next;
  logic last_was_operator, last_was_operator_next;
  logic in_string, in_string_next;
  logic quote_is_single, quote_is_single_next;
  logic prev_backslash, prev_backslash_next;
  logic close_quote;

  // matching quote for the open string
  assign close_quote = quote_is_single ? cls.is_squote : cls.is_dquote;

  // result and next state for the character in the input register
  always_comb begin
    res                    = '0;
    res.char_out           = char_code;
    token_open_next        = token_open;
    last_was_operator_next = last_was_operator;
    in_string_next         = in_string;
    quote_is_single_next   = quote_is_single;
    prev_backslash_next    = prev_backslash;
    if (flush) begin
      res.char_out           = '0;
      res.break_before       = token_open;
      res.line_end           = 1'b1;
      res.stream_end         = 1'b1;
      token_open_next        = 1'b0;
      last_was_operator_next = 1'b0;
      in_string_next         = 1'b0;
      quote_is_single_next   = 1'b0;
      prev_backslash_next    = 1'b0;
    end else if (in_string) begin
      res.part_of_token = 1'b1;
      res.string_mode   = 1'b1;
      if (!prev_backslash && close_quote) begin
        res.break_after     = 1'b1;
        in_string_next      = 1'b0;
        token_open_next     = 1'b0;
        prev_backslash_next = 1'b0;
      end else begin
        prev_backslash_next = cls.is_backslash;
      end
    end else if (cls.is_sym) begin
      res.break_before       = token_open;
      res.part_of_token      = 1'b1;
      last_was_operator_next = 1'b0;
      if (cls.is_dquote || cls.is_squote) begin
        res.string_mode      = 1'b1;
        in_string_next       = 1'b1;
        quote_is_single_next = cls.is_squote;
        prev_backslash_next  = 1'b0;
        token_open_next      = 1'b1;
      end else begin
        res.break_after = 1'b1;
        token_open_next = 1'b0;
      end
    end else if (cls.is_op) begin
      res.break_before       = token_open && !last_was_operator;
      res.part_of_token      = 1'b1;
      token_open_next        = 1'b1;
      last_was_operator_next = 1'b1;
    end else if (cls.is_blank || cls.is_newline) begin
      res.break_before       = token_open;
      res.line_end           = cls.is_newline;
      token_open_next        = 1'b0;
      last_was_operator_next = 1'b0;
    end else begin
      // ordinary character, a new token when it follows an operator run
      res.break_before       = token_open && last_was_operator;
      res.part_of_token      = 1'b1;
      token_open_next        = 1'b1;
      last_was_operator_next = 1'b0;
    end
  end

  // state moves only when the character goes on to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      token_open        <= 1'b0;
      last_was_operator <= 1'b0;
      in_string         <= 1'b0;
      quote_is_single   <= 1'b0;
      prev_backslash    <= 1'b0;
    end else if (advance) begin
      token_open        <= token_open_next;
      last_was_operator <= last_was_operator_next;
      in_string         <= in_string_next;
      quote_is_single   <= quote_is_single_next;
      prev_backslash    <= prev_backslash_next;
    end
  end

  // a string is always an open token
  a_string_is_open: assert property (@(posedge clk) disable iff (rst)
    in_string |-> token_open)
    else $error("string mode without an open token");

  // a flush leaves the state as after reset
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    advance && flush |=> !token_open && !last_was_operator && !in_string &&
                         !quote_is_single && !prev_backslash)
    else $error("state not cleared after flush");

  // escape flag only lives inside a string
  a_escape_in_string: assert property (@(posedge clk) disable iff (rst)
    prev_backslash |-> in_string)
    else $error("escape flag set outside a string");

endmodule

@@ rtl/char_class_tokenizer_top.sv @@
// top level of the character class tokenizer: input register, core, result register
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_ready, char_code, end_of_input | into block
//   out     | out_valid, out_ready, char_out, part_of_token,
//           | break_before, break_after, line_end,
//           | string_mode, stream_end                  | out of block
//
// one character beat per cycle sustained while out_ready stays high; a result passes through
// the input register, then the result register
// rst clears both valid flags and all tokenizer state
// out_ready low holds the result register, then the input register, then in_ready
`timescale 1ns / 1ps

module char_class_tokenizer_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cct_pkg::CHAR_W-1:0] char_code,
  input  logic                       end_of_input,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cct_pkg::CHAR_W-1:0] char_out,
  output logic                       part_of_token,
  output logic                       break_before,
  output logic                       break_after,
  output logic                       line_end,
  output logic                       string_mode,
  output logic                       stream_end
);

  logic                       in_reg_valid;
  logic [cct_pkg::CHAR_W-1:0] in_reg_char;
  logic                       in_reg_flush;
  logic                       res_ready;
  logic                       advance;
  cct_pkg::char_class_t       cls;
  cct_pkg::result_t           res;
  cct_pkg::result_t           out_reg;

  // pipeline flow control
  assign res_ready = !out_valid || out_ready;
  assign advance   = in_reg_valid && res_ready;
  assign in_ready  = !in_reg_valid || res_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_reg_char  <= char_code;
      in_reg_flush <= end_of_input;
    end
  end

  cct_class u_class (
    .char_code (in_reg_char),
    .cls       (cls)
  );

  cct_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .flush     (in_reg_flush),
    .char_code (in_reg_char),
    .cls       (cls),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= res;
    end
  end

  // result beat onto the ports
  assign char_out      = out_reg.char_out;
  assign part_of_token = out_reg.part_of_token;
  assign break_before  = out_reg.break_before;
  assign break_after   = out_reg.break_after;
  assign line_end      = out_reg.line_end;
  assign string_mode   = out_reg.string_mode;
  assign stream_end    = out_reg.stream_end;

  // a token can only end with a character that belongs to it
  a_break_after_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && break_after |-> part_of_token)
    else $error("break after a character outside any token");

  // the flush result closes the line and carries no character
  a_flush_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_end |-> line_end && !part_of_token && !string_mode &&
                                (char_out == '0))
    else $error("malformed flush result");

  // a waiting result beat holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_reg))
    else $error("result beat changed while waiting");

endmodule
